// ===== src/wsd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	localparam logic [1:0] ST_TEXT    = 2'd0;
	localparam logic [1:0] ST_CLOSE   = 2'd1;
	localparam logic [1:0] ST_IGNORED = 2'd2;
	localparam logic [1:0] ST_ERROR   = 2'd3;

	typedef enum logic [0:0] {
		CMD_KEY  = 1'b0,
		CMD_EMIT = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic [1:0] key_idx;
		logic       xor_en;
		logic       byte_valid;
		logic [1:0] status;
		logic       done;
	} cmd_t;

endpackage

// ===== src/wsd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_fifo
// small register queue between the header parser and the unmasking stage
// ----------------------------------------------------------------------------
module wsd_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("queue count beyond depth");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not follow a lone write");
`endif

endmodule

// ===== src/wsd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_front
// frame header parser: checks header, tracks lengths, classifies each byte
// ----------------------------------------------------------------------------
module wsd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	input  logic          buffer_end,
	output logic          cmd_valid,
	output wsd_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		PH_HDR0  = 7'b0000001,
		PH_HDR1  = 7'b0000010,
		PH_EXTHI = 7'b0000100,
		PH_EXTLO = 7'b0001000,
		PH_KEY   = 7'b0010000,
		PH_DATA  = 7'b0100000,
		PH_DROP  = 7'b1000000
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [3:0]  opcode_q, opcode_n;
	logic [15:0] len_q, len_n;
	logic [15:0] idx_q, idx_n;
	logic [15:0] idx_inc;
	logic        op_ok;
	logic        is_text;
	logic [1:0]  op_status;

	assign idx_inc = idx_q + 16'd1;
	assign is_text = (opcode_q == wsd_pkg::OP_TEXT);
	assign op_ok   = (rx_byte[3:0] == wsd_pkg::OP_TEXT) || (rx_byte[3:0] == wsd_pkg::OP_BINARY)
		|| (rx_byte[3:0] == wsd_pkg::OP_CLOSE) || (rx_byte[3:0] == wsd_pkg::OP_PING)
		|| (rx_byte[3:0] == wsd_pkg::OP_PONG);

	always_comb begin
		if (opcode_q == wsd_pkg::OP_TEXT) begin
			op_status = wsd_pkg::ST_TEXT;
		end else if (opcode_q == wsd_pkg::OP_CLOSE) begin
			op_status = wsd_pkg::ST_CLOSE;
		end else begin
			op_status = wsd_pkg::ST_IGNORED;
		end
	end

	always_comb begin
		phase_n        = phase_q;
		opcode_n       = opcode_q;
		len_n          = len_q;
		idx_n          = idx_q;
		cmd_valid      = 1'b0;
		cmd.kind       = wsd_pkg::CMD_EMIT;
		cmd.data       = 8'h00;
		cmd.key_idx    = idx_q[1:0];
		cmd.xor_en     = 1'b0;
		cmd.byte_valid = 1'b0;
		cmd.status     = wsd_pkg::ST_TEXT;
		cmd.done       = 1'b0;
		unique case (phase_q)
			PH_HDR0: begin
				if (!rx_byte[7] || (rx_byte[6:4] != 3'b000) || !op_ok || buffer_end) begin
					cmd_valid  = 1'b1;
					cmd.status = wsd_pkg::ST_ERROR;
					cmd.done   = 1'b1;
					phase_n    = buffer_end ? PH_HDR0 : PH_DROP;
				end else begin
					phase_n = PH_HDR1;
				end
				if (rx_byte[7] && (rx_byte[6:4] == 3'b000) && op_ok) begin
					opcode_n = rx_byte[3:0];
				end
			end
			PH_HDR1: begin
				if (rx_byte[7] && (rx_byte[6:0] != 7'h7f)) begin
					idx_n = '0;
					len_n = (rx_byte[6:0] == 7'h7e) ? 16'h0000 : {9'd0, rx_byte[6:0]};
				end
				if (!rx_byte[7] || (rx_byte[6:0] == 7'h7f) || buffer_end) begin
					cmd_valid  = 1'b1;
					cmd.status = wsd_pkg::ST_ERROR;
					cmd.done   = 1'b1;
					phase_n    = buffer_end ? PH_HDR0 : PH_DROP;
				end else begin
					phase_n = (rx_byte[6:0] == 7'h7e) ? PH_EXTHI : PH_KEY;
				end
			end
			PH_EXTHI: begin
				len_n = {rx_byte, 8'h00};
				if (buffer_end) begin
					cmd_valid  = 1'b1;
					cmd.status = wsd_pkg::ST_ERROR;
					cmd.done   = 1'b1;
					phase_n    = PH_HDR0;
				end else begin
					phase_n = PH_EXTLO;
				end
			end
			PH_EXTLO: begin
				len_n = {len_q[15:8], rx_byte};
				idx_n = '0;
				if (buffer_end) begin
					cmd_valid  = 1'b1;
					cmd.status = wsd_pkg::ST_ERROR;
					cmd.done   = 1'b1;
					phase_n    = PH_HDR0;
				end else begin
					phase_n = PH_KEY;
				end
			end
			PH_KEY: begin
				if (idx_q[1:0] == 2'd3) begin
					idx_n = '0;
					if (len_q == '0) begin
						cmd_valid  = 1'b1;
						cmd.status = op_status;
						cmd.done   = 1'b1;
						phase_n    = buffer_end ? PH_HDR0 : PH_DROP;
					end else if (buffer_end) begin
						cmd_valid  = 1'b1;
						cmd.status = wsd_pkg::ST_ERROR;
						cmd.done   = 1'b1;
						phase_n    = PH_HDR0;
					end else begin
						cmd_valid = 1'b1;
						cmd.kind  = wsd_pkg::CMD_KEY;
						cmd.data  = rx_byte;
						phase_n   = PH_DATA;
					end
				end else begin
					idx_n = idx_inc;
					if (buffer_end) begin
						cmd_valid  = 1'b1;
						cmd.status = wsd_pkg::ST_ERROR;
						cmd.done   = 1'b1;
						phase_n    = PH_HDR0;
					end else begin
						cmd_valid = 1'b1;
						cmd.kind  = wsd_pkg::CMD_KEY;
						cmd.data  = rx_byte;
					end
				end
			end
			PH_DATA: begin
				idx_n = idx_inc;
				if (idx_inc == len_q) begin
					cmd_valid      = 1'b1;
					cmd.data       = is_text ? rx_byte : 8'h00;
					cmd.xor_en     = is_text;
					cmd.byte_valid = is_text;
					cmd.status     = op_status;
					cmd.done       = 1'b1;
					phase_n        = buffer_end ? PH_HDR0 : PH_DROP;
				end else if (buffer_end) begin
					cmd_valid  = 1'b1;
					cmd.status = wsd_pkg::ST_ERROR;
					cmd.done   = 1'b1;
					phase_n    = PH_HDR0;
				end else if (is_text) begin
					cmd_valid      = 1'b1;
					cmd.data       = rx_byte;
					cmd.xor_en     = 1'b1;
					cmd.byte_valid = 1'b1;
				end
			end
			PH_DROP: begin
				if (buffer_end) begin
					phase_n = PH_HDR0;
				end
			end
			default: begin
				phase_n = PH_HDR0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			opcode_q <= '0;
			len_q    <= '0;
			idx_q    <= '0;
		end else if (accept) begin
			phase_q  <= phase_n;
			opcode_q <= opcode_n;
			len_q    <= len_n;
			idx_q    <= idx_n;
		end
	end

`ifndef ASSERT_OFF
	a_key_index: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY) |-> (idx_q < 16'd4))
		else $error("key byte count out of range");
`endif

endmodule

// ===== src/wsd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_back
// unmasking stage: holds the masking key, xors text bytes, output register
// ----------------------------------------------------------------------------
module wsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_avail,
	input  wsd_pkg::cmd_t cmd,
	output logic          cmd_take,
	output logic [7:0]    payload_byte,
	output logic          byte_valid,
	output logic [1:0]    frame_status,
	output logic          frame_done,
	output logic          empty,
	input  logic          pop
);

	logic [7:0] key_q [4];
	logic       out_full_q;
	logic       out_free;
	logic       load;
	logic [7:0] data_x;

	assign out_free = !out_full_q || pop;
	assign cmd_take = cmd_avail && ((cmd.kind == wsd_pkg::CMD_KEY) || out_free);
	assign load     = cmd_take && (cmd.kind == wsd_pkg::CMD_EMIT);
	assign data_x   = cmd.xor_en ? (cmd.data ^ key_q[cmd.key_idx]) : cmd.data;
	assign empty    = !out_full_q;

	always_ff @(posedge clk) begin
		if (cmd_take && (cmd.kind == wsd_pkg::CMD_KEY)) begin
			key_q[cmd.key_idx] <= cmd.data;
		end
		if (load) begin
			payload_byte <= data_x;
			byte_valid   <= cmd.byte_valid;
			frame_status <= cmd.status;
			frame_done   <= cmd.done;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_full_q <= 1'b0;
		end else if (load) begin
			out_full_q <= 1'b1;
		end else if (pop) begin
			out_full_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_mid_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !frame_done) |-> (byte_valid && (frame_status == wsd_pkg::ST_TEXT)))
		else $error("result without frame end is not a text byte");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(payload_byte) && $stable(frame_done)))
		else $error("waiting result changed");
`endif

endmodule

// ===== src/websocket_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// client-to-server frame header check and text payload unmasking
//
//   channel   handshake     payload
//   input     push / full   rx_byte, buffer_end
//   result    pop / empty   payload_byte, byte_valid, frame_status, frame_done
//
// one byte per cycle is accepted while full is low; a result passes through
// the command queue and the output register after its byte is accepted. full
// rises only when the command queue is backed up by a stalled result side.
// arst_n clears the parser state, queue pointers and the output flag; the
// masking key needs no reset.
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
	parameter int QUEUE_DEPTH = wsd_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	input  logic       buffer_end,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] payload_byte,
	output logic       byte_valid,
	output logic [1:0] frame_status,
	output logic       frame_done
);

	localparam int CMD_W = $bits(wsd_pkg::cmd_t);

	logic          accept;
	logic          cmd_valid;
	wsd_pkg::cmd_t cmd_in;
	logic [CMD_W-1:0] q_wdata;
	logic [CMD_W-1:0] q_rdata;
	wsd_pkg::cmd_t cmd_out;
	logic          q_empty;
	logic          q_take;

	assign accept  = push && !full;
	assign q_wdata = cmd_in;
	assign cmd_out = wsd_pkg::cmd_t'(q_rdata);

	wsd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.buffer_end (buffer_end),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd_in)
	);

	wsd_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (accept && cmd_valid),
		.wdata  (q_wdata),
		.full   (full),
		.rd     (q_take),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	wsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_avail    (!q_empty),
		.cmd          (cmd_out),
		.cmd_take     (q_take),
		.payload_byte (payload_byte),
		.byte_valid   (byte_valid),
		.frame_status (frame_status),
		.frame_done   (frame_done),
		.empty        (empty),
		.pop          (pop)
	);

endmodule
